/* rtl/core/skk_pkg.sv */
// skk_pkg: shared types and fixed widths for the k-smallest keeper.
// No dependencies; used by skk_ctrl, skk_datapath and the top level.
package skk_pkg;

    localparam int VALUE_W    = 32;
    localparam int KEEP_CFG_W = 6;
    localparam logic [KEEP_CFG_W-1:0] KEEP_RESET = 6'd32;

    // controller -> datapath
    typedef struct packed {
        logic insert;   // process the accepted value
        logic emit;     // one output beat: shift chain toward the head
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_one; // exactly one entry held
    } t_dp_sts;

endpackage

/* rtl/core/streaming_k_smallest_keeper_unit.sv */
// streaming_k_smallest_keeper_unit: top level of the k-smallest keeper.
// Depends on skk_pkg, skk_ctrl and skk_datapath.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | i_value, i_end_of_set                   | i_start & !o_busy
//  result   | o_kept_value, o_last_kept               | o_valid, no stall
//  config   | i_cfg_data (keep_count)                 | i_cfg_valid & o_cfg_ready
//
// A value without end_of_set leaves o_busy low, so a new beat may follow at once.
// A beat with end_of_set is processed like any other value, then o_busy stays
// high while the chain drains one entry per beat, head first, smallest value
// out first; o_last_kept marks the final beat and the chain is empty after it.
// The drain length is set by the number of held entries (1..MAX_KEEP).
// Reset (synchronous, active low) empties the chain and sets keep_count to 32.
// Results cannot be held off; config is always ready and is meant for idle use.
module streaming_k_smallest_keeper_unit #(
    parameter int MAX_KEEP = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [skk_pkg::VALUE_W-1:0]    i_value,
    input  logic                                  i_end_of_set,
    output logic                                  o_valid,
    output logic signed [skk_pkg::VALUE_W-1:0]    o_kept_value,
    output logic                                  o_last_kept,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [skk_pkg::KEEP_CFG_W-1:0]        i_cfg_data
);

    skk_pkg::t_dp_cmd cmd;
    skk_pkg::t_dp_sts sts;

    // keep_count register; clipping to the chain length is done in the datapath
    logic [skk_pkg::KEEP_CFG_W-1:0] r_keep_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= skk_pkg::KEEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_keep_count <= i_cfg_data;
        end
    end

    skk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_end_of_set (i_end_of_set),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_last       (o_last_kept)
    );

    // sorted chain: head cell feeds the result port during the drain
    skk_datapath #(
        .MAX_KEEP (MAX_KEEP)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_keep_count (r_keep_count),
        .o_sts        (sts),
        .o_head_value (o_kept_value)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !cmd.insert)
        else $error("insert while draining");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_kept) |=> !o_busy)
        else $error("drain continued past last beat");

    a_eos_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_end_of_set) |=> o_valid)
        else $error("end of set did not start a drain");
`endif

endmodule

/* rtl/core/skk_ctrl.sv */
// skk_ctrl: accept/emit sequencer for the k-smallest keeper.
// Depends on skk_pkg (command and status structs).
module skk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_end_of_set,
    input  skk_pkg::t_dp_sts  i_sts,
    output skk_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid,
    output logic              o_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_end_of_set) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.last_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy     = (r_state == ST_EMIT);
    assign o_cmd.insert = (r_state == ST_IDLE) && i_start;
    assign o_cmd.emit   = (r_state == ST_EMIT);
    assign o_valid    = (r_state == ST_EMIT);
    assign o_last     = (r_state == ST_EMIT) && i_sts.last_one;

endmodule

/* rtl/core/skk_datapath.sv */
// skk_datapath: sorted register chain with per-cell compare, insert and drain.
// Depends on skk_pkg (command/status structs, widths).
module skk_datapath #(
    parameter int MAX_KEEP = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  skk_pkg::t_dp_cmd                      i_cmd,
    input  logic signed [skk_pkg::VALUE_W-1:0]    i_value,
    input  logic [skk_pkg::KEEP_CFG_W-1:0]        i_keep_count,
    output skk_pkg::t_dp_sts                      o_sts,
    output logic signed [skk_pkg::VALUE_W-1:0]    o_head_value
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int EW = (CW > skk_pkg::KEEP_CFG_W) ? CW : skk_pkg::KEEP_CFG_W;

    logic signed [skk_pkg::VALUE_W-1:0] r_entry [MAX_KEEP];
    logic signed [skk_pkg::VALUE_W-1:0] n_entry [MAX_KEEP];
    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;

    logic [EW-1:0]       eff_k;
    logic                full;
    logic                replace;
    logic                do_ins;
    logic [CW-1:0]       h_ins;
    logic [MAX_KEEP-1:0] lt;
    logic [MAX_KEEP-1:0] lt_eff;
    logic [MAX_KEEP-1:0] take;

    always_comb begin
        // zero keep count acts as one, large values clip to the chain length
        if (i_keep_count == '0) begin
            eff_k = EW'(1);
        end else if (EW'(i_keep_count) > EW'(MAX_KEEP)) begin
            eff_k = EW'(MAX_KEEP);
        end else begin
            eff_k = EW'(i_keep_count);
        end
        full = (EW'(r_held) >= eff_k);

        // chain is sorted, so lt is a thermometer over the valid cells
        for (int i = 0; i < MAX_KEEP; i++) begin
            lt[i] = (i_value < r_entry[i]) && (CW'(i) < r_held);
        end
        replace = |lt;
        do_ins  = i_cmd.insert && (!full || replace);
        h_ins   = full ? (r_held - CW'(1)) : r_held;

        for (int i = 0; i < MAX_KEEP; i++) begin
            lt_eff[i] = lt[i] && (CW'(i) < h_ins);
            take[i]   = lt_eff[i] || (CW'(i) == h_ins);
        end

        for (int i = 0; i < MAX_KEEP; i++) begin
            n_entry[i] = r_entry[i];
        end
        n_held = r_held;

        if (do_ins) begin
            if (take[0]) begin
                n_entry[0] = i_value;
            end
            for (int i = 1; i < MAX_KEEP; i++) begin
                if (take[i]) begin
                    n_entry[i] = lt_eff[i-1] ? r_entry[i-1] : i_value;
                end
            end
            n_held = h_ins + CW'(1);
        end else if (i_cmd.emit) begin
            for (int i = 0; i < MAX_KEEP - 1; i++) begin
                n_entry[i] = r_entry[i+1];
            end
            n_held = r_held - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            r_entry[i] <= n_entry[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    assign o_sts.last_one = (r_held == CW'(1));
    assign o_head_value   = r_entry[0];

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_held) <= EW'(MAX_KEEP))
        else $error("held count beyond chain length");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_held != '0))
        else $error("emit beat with empty chain");

    a_emit_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_held == $past(r_held) - CW'(1)))
        else $error("emit beat did not drop one entry");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.insert && i_cmd.emit))
        else $error("insert and emit in the same cycle");
`endif

endmodule
